### design/rmlq_pkg.sv
// Package for the range maximum linear query block.
// Holds table size, field widths, command codes and saturation limit.
// Depends on nothing.
package rmlq_pkg;

   // Table of lines
   localparam int MAX_LINES = 1024;
   localparam int IDX_W     = $clog2(MAX_LINES);
   localparam int CNT_W     = IDX_W + 1;

   // Field widths
   localparam int COEF_W  = 30;
   localparam int TIME_W  = 20;
   localparam int PROD_W  = COEF_W + TIME_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int VALUE_W = 50;
   localparam int END_W   = 11;

   // Command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Reported value saturates here
   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

   // Stored line: slope and intercept side by side
   typedef struct packed {
      logic [COEF_W-1:0] slope;
      logic [COEF_W-1:0] intercept;
   } line_type;

endpackage

### design/range_max_linear_query.sv
// Range maximum linear query: table of lines and a sequenced scan over a range.
// Depends on rmlq_pkg for widths, command codes and the line type.
//
// Usage
//    Commands enter on the req_ ports, taken at a rising edge with start high
//    and busy low. A load (req_command = 0) writes one line of the table at
//    req_line_position and gives no result; busy never rises for it, so the
//    next item may follow in the next cycle. A query (req_command = 1) scans
//    positions [req_range_first, min(req_range_end, 1024)) and returns the
//    position and value of the line whose slope * time + intercept is
//    greatest, the largest position winning on ties.
//    A query reads one line a cycle from the single read port of
//    the line memory and feeds one shared 30 x 20 multiplier and one
//    51-bit add and compare; busy stays high while the lines are read,
//    multiplied, added and compared, and drops as the result is shown.
//    An empty range gives its result (found = 0) in the cycle after it
//    is taken, with busy staying low.
//    Each result is on the rsp_ ports for exactly one cycle, marked by
//    rsp_strobe; the receiver cannot stall. A new item may be taken in the
//    cycle that a result is shown.
//    Reset returns the sequencer to idle and clears the strobe. The table is
//    not cleared: a line must be loaded before a query covers it.
module range_max_linear_query
   import rmlq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic [IDX_W-1:0]   req_line_position,
   input  logic [COEF_W-1:0]  req_slope,
   input  logic [COEF_W-1:0]  req_intercept,
   input  logic [IDX_W-1:0]   req_range_first,
   input  logic [END_W-1:0]   req_range_end,
   input  logic [TIME_W-1:0]  req_query_time,
   output logic               rsp_strobe,
   output logic               rsp_found,
   output logic [IDX_W-1:0]   rsp_best_position,
   output logic [VALUE_W-1:0] rsp_best_value
);

   // Sequencer codes
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   addr_ff, addr_in;
   logic [CNT_W-1:0]   end_ff, end_in;
   logic [CNT_W-1:0]   first_ff, first_in;
   logic [TIME_W-1:0]  time_ff, time_in;

   line_type           line_mem_ff [MAX_LINES];
   line_type           rd_line_ff;
   logic [IDX_W-1:0]   pos1_ff;
   logic               v1_ff, v1_in;

   logic [PROD_W-1:0]  prod_ff;
   logic [COEF_W-1:0]  icpt_ff;
   logic [IDX_W-1:0]   pos2_ff;
   logic               v2_ff, v2_in;

   logic [SUM_W-1:0]   best_val_ff, best_val_in;
   logic [IDX_W-1:0]   best_pos_ff, best_pos_in;
   logic               any_ff, any_in;

   logic               rsp_strobe_ff, rsp_strobe_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [VALUE_W-1:0] rsp_val_ff, rsp_val_in;

   logic               accept;
   logic [CNT_W-1:0]   req_first_ext;
   logic [CNT_W-1:0]   req_end_clip;
   logic [CNT_W-1:0]   addr_next;
   logic [SUM_W-1:0]   sum;
   logic               take;
   logic [VALUE_W-1:0] best_sat;

   assign accept        = start && !busy;
   assign req_first_ext = {1'b0, req_range_first};
   assign req_end_clip  = (req_range_end > END_W'(MAX_LINES)) ? CNT_W'(MAX_LINES)
                                                               : CNT_W'(req_range_end);
   assign addr_next     = addr_ff + CNT_W'(1);

   // Combine product and intercept, decide whether this line takes the lead
   assign sum  = {1'b0, prod_ff} + SUM_W'(icpt_ff);
   assign take = v2_ff && (!any_ff || (sum >= best_val_ff));

   // Saturate the reported value
   assign best_sat = best_val_ff[SUM_W-1] ? VALUE_MAX : best_val_ff[VALUE_W-1:0];

   // Sequencer and scan control
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      end_in        = end_ff;
      first_in      = first_ff;
      time_in       = time_ff;
      v1_in         = 1'b0;
      v2_in         = v1_ff;
      best_val_in   = best_val_ff;
      best_pos_in   = best_pos_ff;
      any_in        = any_ff;
      rsp_strobe_in = 1'b0;
      rsp_found_in  = rsp_found_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_val_in    = rsp_val_ff;

      if (take) begin
         best_val_in = sum;
         best_pos_in = pos2_ff;
         any_in      = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept && (req_command == CMD_QUERY)) begin
               first_in = req_first_ext;
               end_in   = req_end_clip;
               time_in  = req_query_time;
               addr_in  = req_first_ext;
               any_in   = 1'b0;
               if (req_first_ext >= req_end_clip) begin
                  // Empty range: answer at once
                  rsp_strobe_in = 1'b1;
                  rsp_found_in  = 1'b0;
                  rsp_pos_in    = '0;
                  rsp_val_in    = '0;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // Issue one read a cycle
            v1_in   = 1'b1;
            addr_in = addr_next;
            if (addr_next == end_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // Wait for the last line to pass the compare
            if (!v1_ff && !v2_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_found_in  = 1'b1;
               rsp_pos_in    = best_pos_ff;
               rsp_val_in    = best_sat;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         any_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         v1_ff         <= v1_in;
         v2_ff         <= v2_in;
         any_ff        <= any_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      end_ff       <= end_in;
      first_ff     <= first_in;
      time_ff      <= time_in;
      best_val_ff  <= best_val_in;
      best_pos_ff  <= best_pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_val_ff   <= rsp_val_in;
   end

   // Line memory: write on load, registered read during scan
   always_ff @(posedge clock) begin
      if (accept && (req_command == CMD_LOAD)
          && ({1'b0, req_line_position} < CNT_W'(MAX_LINES))) begin
         line_mem_ff[req_line_position] <= '{slope: req_slope, intercept: req_intercept};
      end
      rd_line_ff <= line_mem_ff[addr_ff[IDX_W-1:0]];
      pos1_ff    <= addr_ff[IDX_W-1:0];
   end

   // Shared multiplier stage
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(rd_line_ff.slope) * PROD_W'(time_ff);
      icpt_ff <= rd_line_ff.intercept;
      pos2_ff <= pos1_ff;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_best_position = rsp_pos_ff;
   assign rsp_best_value    = rsp_val_ff;

   // Checks
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe raised while a scan is running");

   a_found_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_found) |->
         ({1'b0, rsp_best_position} >= first_ff) && ({1'b0, rsp_best_position} < end_ff))
      else $error("reported position lies outside the query range");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_found) |-> (rsp_best_position == '0) && (rsp_best_value == '0))
      else $error("empty range result not zero");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (addr_ff < end_ff))
      else $error("scan address ran past the range end");

   a_drain_after_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == S_DRAIN) |-> $past(state_ff) == S_SCAN)
      else $error("drain entered without a scan");

endmodule

### tb/range_max_linear_query_test.sv
`timescale 1ns / 100ps
// Testbench for range_max_linear_query: loads lines, runs range queries and checks
// each answer against a scan over its own copy of the line table.
// Depends on rmlq_pkg and the range_max_linear_query RTL.
module range_max_linear_query_test
   import rmlq_pkg::*;
();

   localparam int CYCLE_LIMIT   = 5000000;
   localparam int SETTLE_CYCLES = 1100;
   localparam int PRINT_LIMIT   = 40;
   localparam int TOP_LINES     = 128;
   localparam logic [COEF_W-1:0] COEF_TOP = 30'd1000000000;
   localparam logic [TIME_W-1:0] TIME_TOP = 20'd1000000;

   typedef struct packed {
      logic               found;
      logic [IDX_W-1:0]   position;
      logic [VALUE_W-1:0] value;
   } answer_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_command = CMD_LOAD;
   logic [IDX_W-1:0]   req_line_position = '0;
   logic [COEF_W-1:0]  req_slope = '0;
   logic [COEF_W-1:0]  req_intercept = '0;
   logic [IDX_W-1:0]   req_range_first = '0;
   logic [END_W-1:0]   req_range_end = '0;
   logic [TIME_W-1:0]  req_query_time = '0;
   logic               rsp_strobe;
   logic               rsp_found;
   logic [IDX_W-1:0]   rsp_best_position;
   logic [VALUE_W-1:0] rsp_best_value;

   // Line table as the block should hold it, and which positions hold a line
   logic [COEF_W-1:0]    slope_table [MAX_LINES];
   logic [COEF_W-1:0]    intercept_table [MAX_LINES];
   logic [MAX_LINES-1:0] written_mask = '0;
   logic [IDX_W-1:0]     fill_next = IDX_W'(5);

   answer_type pending_answers [$];
   int         error_count = 0;
   int         cycle_count = 0;
   int         sender_idle_pct = 0;

   range_max_linear_query dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Give up on a hung block
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_LIMIT)
         $display("ERROR cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // Scan the range and keep the greatest value, the later position winning ties
   function automatic answer_type best_line(input logic [IDX_W-1:0] first,
                                            input logic [END_W-1:0] last_excl,
                                            input logic [TIME_W-1:0] t);
      answer_type       ans;
      logic [SUM_W-1:0] best;
      logic [SUM_W-1:0] cand;
      int               stop;
      ans  = '0;
      best = '0;
      stop = (last_excl > MAX_LINES) ? MAX_LINES : int'(last_excl);
      for (int k = first; k < stop; k++) begin
         cand = slope_table[k] * t + intercept_table[k];
         if (!ans.found || cand >= best) begin
            best         = cand;
            ans.found    = 1'b1;
            ans.position = IDX_W'(k);
         end
      end
      if (ans.found)
         ans.value = (best > VALUE_MAX) ? VALUE_MAX : best[VALUE_W-1:0];
      return ans;
   endfunction

   // Compare each answer with the oldest one awaited
   always @(negedge clock) begin : check_answers
      answer_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("answer with no query waiting");
         end else begin
            want = pending_answers.pop_front();
            if (rsp_found !== want.found)
               report_mismatch($sformatf("found: expected %0d, got %0d",
                                         want.found, rsp_found));
            if (rsp_best_position !== want.position)
               report_mismatch($sformatf("best_position: expected %0d, got %0d",
                                         want.position, rsp_best_position));
            if (rsp_best_value !== want.value)
               report_mismatch($sformatf("best_value: expected %0d, got %0d",
                                         want.value, rsp_best_value));
         end
      end
   end

   // Offer one item, hold it until taken, then update the table or await an answer
   task automatic send_item(input logic cmd, input logic [IDX_W-1:0] pos,
                            input logic [COEF_W-1:0] slope, input logic [COEF_W-1:0] icpt,
                            input logic [IDX_W-1:0] first, input logic [END_W-1:0] last_excl,
                            input logic [TIME_W-1:0] t);
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) < sender_idle_pct)
         gap = $urandom_range(1, 4);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_command       <= cmd;
      req_line_position <= pos;
      req_slope         <= slope;
      req_intercept     <= icpt;
      req_range_first   <= first;
      req_range_end     <= last_excl;
      req_query_time    <= t;
      do @(negedge clock); while (busy !== 1'b0);
      @(posedge clock);
      if (cmd == CMD_LOAD) begin
         slope_table[pos]     = slope;
         intercept_table[pos] = icpt;
         written_mask[pos]    = 1'b1;
      end else begin
         pending_answers = {pending_answers, best_line(first, last_excl, t)};
      end
   endtask

   task automatic load_line(input logic [IDX_W-1:0] pos, input logic [COEF_W-1:0] slope,
                            input logic [COEF_W-1:0] icpt);
      send_item(CMD_LOAD, pos, slope, icpt,
                IDX_W'($urandom), END_W'($urandom), TIME_W'($urandom));
   endtask

   task automatic run_query(input logic [IDX_W-1:0] first, input logic [END_W-1:0] last_excl,
                            input logic [TIME_W-1:0] t);
      send_item(CMD_QUERY, IDX_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                first, last_excl, t);
   endtask

   // Hold off until every awaited answer is in
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   // Small values give plenty of ties; a few go past the stated range
   function automatic logic [COEF_W-1:0] random_coef();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 20)
         return COEF_W'($urandom_range(0, 7));
      else if (pick < 25)
         return COEF_W'($urandom_range(COEF_TOP, {COEF_W{1'b1}}));
      else
         return COEF_W'($urandom_range(0, COEF_TOP));
   endfunction

   function automatic logic [TIME_W-1:0] random_time();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 15)
         return '0;
      else if (pick < 30)
         return TIME_W'($urandom_range(1, 7));
      else if (pick < 40)
         return TIME_W'($urandom_range(TIME_TOP, {TIME_W{1'b1}}));
      else
         return TIME_W'($urandom_range(0, TIME_TOP));
   endfunction

   // Query a run of loaded lines, mostly short, now and then an empty range
   task automatic random_query();
      logic [IDX_W-1:0] first;
      logic [END_W-1:0] last_excl;
      int               run;
      int               span;
      int               tries;
      if ($urandom_range(0, 99) < 8) begin
         first     = IDX_W'($urandom_range(0, MAX_LINES - 1));
         last_excl = END_W'($urandom_range(0, first));
      end else begin
         tries = 0;
         do begin
            first = IDX_W'($urandom_range(0, MAX_LINES - 1));
            tries++;
         end while (!written_mask[first] && tries < 64);
         // position 0 is always loaded by the directed tests
         if (!written_mask[first])
            first = '0;
         run = 0;
         while (first + run < MAX_LINES && written_mask[first + run])
            run++;
         if ($urandom_range(0, 99) < 80)
            span = $urandom_range(1, (run < 32) ? run : 32);
         else
            span = $urandom_range(1, run);
         last_excl = END_W'(first + span);
         // an end past the table clips to the last line
         if (first + span == MAX_LINES && $urandom_range(0, 1) == 1)
            last_excl = END_W'($urandom_range(MAX_LINES, {END_W{1'b1}}));
      end
      run_query(first, last_excl, random_time());
   endtask

   // Extreme coefficients and times, both table ends, clipping, reload of a line
   task automatic test_extremes();
      load_line(IDX_W'(0), '0, '0);
      load_line(IDX_W'(1), COEF_TOP, COEF_TOP);
      load_line(IDX_W'(2), {COEF_W{1'b1}}, {COEF_W{1'b1}});
      load_line(IDX_W'(MAX_LINES - 1), COEF_W'(1), '0);
      load_line(IDX_W'(MAX_LINES - 2), '0, COEF_W'(1000));
      run_query(IDX_W'(0), END_W'(1), '0);
      run_query(IDX_W'(0), END_W'(2), TIME_TOP);
      run_query(IDX_W'(0), END_W'(3), {TIME_W{1'b1}});
      run_query(IDX_W'(MAX_LINES - 2), END_W'(MAX_LINES), '0);
      run_query(IDX_W'(MAX_LINES - 2), END_W'(MAX_LINES), TIME_W'(2000));
      run_query(IDX_W'(MAX_LINES - 1), {END_W{1'b1}}, {TIME_W{1'b1}});
      // query straight after rewriting the line it reads
      load_line(IDX_W'(0), COEF_TOP, '0);
      run_query(IDX_W'(0), END_W'(1), TIME_TOP);
   endtask

   // Equal lines must report the later position; empty ranges report nothing found
   task automatic test_ties_and_empty_ranges();
      load_line(IDX_W'(3), COEF_W'(5), COEF_W'(7));
      load_line(IDX_W'(4), COEF_W'(5), COEF_W'(7));
      run_query(IDX_W'(3), END_W'(5), TIME_W'(10));
      run_query(IDX_W'(3), END_W'(5), '0);
      run_query(IDX_W'(5), END_W'(5), TIME_TOP);
      run_query(IDX_W'(MAX_LINES - 1), END_W'(5), {TIME_W{1'b1}});
      run_query(IDX_W'(0), END_W'(0), '0);
   endtask

   // Mixed loads and queries; half the loads extend a contiguous run of lines
   task automatic test_random_mix(input int count);
      logic [IDX_W-1:0] pos;
      repeat (count) begin
         if ($urandom_range(0, 99) < 40) begin
            if ($urandom_range(0, 1) == 1) begin
               pos       = fill_next;
               fill_next = fill_next + 1'b1;
            end else begin
               pos = IDX_W'($urandom_range(0, MAX_LINES - 1));
            end
            load_line(pos, random_coef(), random_coef());
         end else begin
            random_query();
         end
      end
   endtask

   // Fill the top of the table, then scan it with the end clipped and unclipped
   task automatic test_table_end();
      for (int k = MAX_LINES - TOP_LINES; k < MAX_LINES; k++)
         load_line(IDX_W'(k), random_coef(), random_coef());
      run_query(IDX_W'(MAX_LINES - TOP_LINES), END_W'(MAX_LINES), random_time());
      run_query(IDX_W'(MAX_LINES - TOP_LINES), {END_W{1'b1}}, {TIME_W{1'b1}});
      run_query(IDX_W'(MAX_LINES - TOP_LINES), END_W'(MAX_LINES), '0);
      run_query(IDX_W'(MAX_LINES - TOP_LINES / 2), END_W'(MAX_LINES), random_time());
   endtask

   initial begin
      sender_idle_pct = 28;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      test_ties_and_empty_ranges();
      test_random_mix(143);
      drain_results();
      sender_idle_pct = 70;
      test_random_mix(143);
      drain_results();
      sender_idle_pct = 0;
      test_random_mix(142);
      test_table_end();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
